/* src/emr_pkg.sv */
// Package: shared types, constants and helper functions of the Euler matrix generator.
`default_nettype none
package emr_pkg;

  localparam int unsigned CordicSteps = 14;
  localparam logic signed [19:0] CordicX0 = 20'sd39797;
  localparam logic signed [15:0] OneQ14 = 16'sd16384;
  localparam int unsigned NumOps = 14;

  // Operand sources of the serial multiplier
  typedef enum logic [2:0] {
    SRC_SX, SRC_CX, SRC_SY, SRC_CY, SRC_SZ, SRC_CZ, SRC_TA, SRC_TB
  } src_e;

  // Preload of the product accumulator
  typedef enum logic [1:0] {
    INI_NONE, INI_PLUS, INI_MINUS
  } ini_e;

  // Where a finished product goes
  typedef enum logic [3:0] {
    DST_M00, DST_M01, DST_M02, DST_M10, DST_M11, DST_M12, DST_M21, DST_M22,
    DST_TA, DST_TB, DST_TC
  } dst_e;

  typedef struct packed {
    src_e a;
    src_e b;
    ini_e ini;
    dst_e dst;
  } op_t;

  typedef struct packed {
    logic signed [15:0] sin;
    logic signed [15:0] cos;
  } sincos_t;

  // CORDIC arc table in phase units (65536 per turn)
  function automatic logic [13:0] atan_lut(input logic [3:0] idx);
    logic [13:0] v;
    case (idx)
      4'd0:    v = 14'd8192;
      4'd1:    v = 14'd4836;
      4'd2:    v = 14'd2555;
      4'd3:    v = 14'd1297;
      4'd4:    v = 14'd651;
      4'd5:    v = 14'd326;
      4'd6:    v = 14'd163;
      4'd7:    v = 14'd81;
      4'd8:    v = 14'd41;
      4'd9:    v = 14'd20;
      4'd10:   v = 14'd10;
      4'd11:   v = 14'd5;
      4'd12:   v = 14'd3;
      4'd13:   v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

  // Product schedule: two-factor entries, partial products, three-factor sums
  function automatic op_t op_lut(input logic [3:0] idx);
    op_t o;
    case (idx)
      4'd0:    o = '{SRC_CZ, SRC_CY, INI_NONE,  DST_M00};
      4'd1:    o = '{SRC_SZ, SRC_CY, INI_NONE,  DST_M10};
      4'd2:    o = '{SRC_CY, SRC_SX, INI_NONE,  DST_M21};
      4'd3:    o = '{SRC_CY, SRC_CX, INI_NONE,  DST_M22};
      4'd4:    o = '{SRC_CZ, SRC_SY, INI_NONE,  DST_TA};
      4'd5:    o = '{SRC_SZ, SRC_SY, INI_NONE,  DST_TB};
      4'd6:    o = '{SRC_SZ, SRC_CX, INI_NONE,  DST_TC};
      4'd7:    o = '{SRC_TA, SRC_SX, INI_MINUS, DST_M01};
      4'd8:    o = '{SRC_SZ, SRC_SX, INI_NONE,  DST_TC};
      4'd9:    o = '{SRC_TA, SRC_CX, INI_PLUS,  DST_M02};
      4'd10:   o = '{SRC_CZ, SRC_CX, INI_NONE,  DST_TC};
      4'd11:   o = '{SRC_TB, SRC_SX, INI_PLUS,  DST_M11};
      4'd12:   o = '{SRC_CZ, SRC_SX, INI_NONE,  DST_TC};
      default: o = '{SRC_TB, SRC_CX, INI_MINUS, DST_M12};
    endcase
    return o;
  endfunction

  // Round half up by 14 or 28 bits and clamp to +-1.0 in Q2.14
  function automatic logic signed [15:0] rnd_sat(input logic signed [47:0] v,
                                                 input logic wide);
    logic signed [47:0] r;
    logic signed [15:0] q;
    if (wide) r = (v + 48'sd134217728) >>> 28;
    else      r = (v + 48'sd8192) >>> 14;
    if (r > 48'sd16384)       q = OneQ14;
    else if (r < -48'sd16384) q = -OneQ14;
    else                      q = r[15:0];
    return q;
  endfunction

endpackage
`default_nettype wire

/* src/emr_if.sv */
// Interfaces: angle step channel and matrix result channel.
`default_nettype none
interface emr_step_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] step_x;
  logic signed [15:0] step_y;
  logic signed [15:0] step_z;
  modport source (output valid, step_x, step_y, step_z, input ready);
  modport sink (input valid, step_x, step_y, step_z, output ready);
endinterface

interface emr_mat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface
`default_nettype wire

/* src/emr_cordic.sv */
// Iterative CORDIC: sine and cosine of a 16-bit phase, one micro-rotation per cycle.
`default_nettype none
module emr_cordic
  import emr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [15:0] phase_i,
  output logic             done_o,
  output sincos_t          res_o
);

  logic signed [19:0] x_q, y_q, x_d, y_d, dx, dy, xr, yr;
  logic signed [17:0] z_q, z_d, z_fold, arc;
  logic               flip_q, flip_fold, run_q, done_q;
  logic [3:0]         it_q;
  logic signed [15:0] xs, ys;

  // Fold the phase into a quarter turn either side of zero
  always_comb begin
    z_fold    = {{2{phase_i[15]}}, phase_i};
    flip_fold = 1'b0;
    if (z_fold > 18'sd16384) begin
      z_fold    = z_fold - 18'sd32768;
      flip_fold = 1'b1;
    end else if (z_fold < -18'sd16384) begin
      z_fold    = z_fold + 18'sd32768;
      flip_fold = 1'b1;
    end
  end

  // One micro-rotation
  always_comb begin
    dx  = y_q >>> it_q;
    dy  = x_q >>> it_q;
    arc = {4'd0, atan_lut(it_q)};
    if (!z_q[17]) begin
      x_d = x_q - dx;
      y_d = y_q + dy;
      z_d = z_q - arc;
    end else begin
      x_d = x_q + dx;
      y_d = y_q - dy;
      z_d = z_q + arc;
    end
  end

  // Round to Q2.14 and clamp
  always_comb begin
    xr = (x_d + 20'sd2) >>> 2;
    yr = (y_d + 20'sd2) >>> 2;
    if (xr > 20'sd16384)       xs = OneQ14;
    else if (xr < -20'sd16384) xs = -OneQ14;
    else                       xs = xr[15:0];
    if (yr > 20'sd16384)       ys = OneQ14;
    else if (yr < -20'sd16384) ys = -OneQ14;
    else                       ys = yr[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        it_q  <= '0;
      end else if (run_q) begin
        it_q <= it_q + 4'd1;
        if (it_q == 4'(CordicSteps - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CordicX0;
      y_q    <= '0;
      z_q    <= z_fold;
      flip_q <= flip_fold;
    end else if (run_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
      if (it_q == 4'(CordicSteps - 1)) begin
        res_o.cos <= flip_q ? -xs : xs;
        res_o.sin <= flip_q ? -ys : ys;
      end
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

/* src/emr_mul.sv */
// Bit-serial signed multiplier with accumulator preload, one multiplier bit per cycle.
`default_nettype none
module emr_mul (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [15:0] b_i,
  input  wire logic signed [47:0] init_i,
  output logic                    done_o,
  output logic signed [47:0]      prod_o
);

  logic signed [47:0] a_sh_q, acc_q;
  logic [15:0]        b_sh_q;
  logic [3:0]         cnt_q;
  logic               run_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift-add; the sign bit of the multiplier carries negative weight
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_sh_q <= {{16{a_i[31]}}, a_i};
      b_sh_q <= b_i;
      acc_q  <= init_i;
    end else if (run_q) begin
      if (b_sh_q[0]) acc_q <= (cnt_q == 4'd15) ? acc_q - a_sh_q : acc_q + a_sh_q;
      a_sh_q <= a_sh_q <<< 1;
      b_sh_q <= b_sh_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule
`default_nettype wire

/* src/euler_rotation_matrix_gen.sv */
// ZYX Euler rotation matrix generator: one Q2.14 matrix Rz*Ry*Rx per angle step item,
// taken from the phases held before the step is added. Each item passes, from its transfer
// until the next step is taken, through three passes of one shared iterative
// CORDIC (14 micro-rotations each), then fourteen passes of one bit-serial 32x16
// multiplier, then an output handoff that waits while the previous matrix is unaccepted.
// The finished matrix sits in an output register, so a new step may be taken meanwhile.
`default_nettype none
module euler_rotation_matrix_gen
  import emr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  emr_step_if.sink   step_in,
  emr_mat_if.source  mat_out
);

  typedef enum logic [2:0] {S_IDLE, S_CSTART, S_CWAIT, S_MSTART, S_MWAIT, S_OUT} state_e;

  state_e             state_q;
  logic [15:0]        ph_x_q, ph_y_q, ph_z_q;
  logic [15:0]        ang_q [3];
  logic signed [15:0] sin_q [3];
  logic signed [15:0] cos_q [3];
  logic [1:0]         ax_q;
  logic [3:0]         op_q;
  logic signed [31:0] ta_q, tb_q, tc_q;
  logic signed [15:0] m00_q, m01_q, m02_q, m10_q, m11_q, m12_q, m21_q, m22_q;
  logic               out_valid_q;

  logic               cor_done, mul_done;
  sincos_t            cor_res;
  op_t                op;
  logic signed [31:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [47:0] mul_init, tc_sh, prod;
  logic signed [15:0] rnd;

  // Operand selection for the current product
  function automatic logic signed [31:0] pick(input src_e s,
      input logic signed [15:0] sx, input logic signed [15:0] cx,
      input logic signed [15:0] sy, input logic signed [15:0] cy,
      input logic signed [15:0] sz, input logic signed [15:0] cz,
      input logic signed [31:0] ta, input logic signed [31:0] tb);
    logic signed [31:0] v;
    case (s)
      SRC_SX:  v = 32'(sx);
      SRC_CX:  v = 32'(cx);
      SRC_SY:  v = 32'(sy);
      SRC_CY:  v = 32'(cy);
      SRC_SZ:  v = 32'(sz);
      SRC_CZ:  v = 32'(cz);
      SRC_TA:  v = ta;
      default: v = tb;
    endcase
    return v;
  endfunction

  always_comb begin
    op       = op_lut(op_q);
    mul_a    = pick(op.a, sin_q[0], cos_q[0], sin_q[1], cos_q[1], sin_q[2], cos_q[2],
                    ta_q, tb_q);
    mul_b    = 16'(pick(op.b, sin_q[0], cos_q[0], sin_q[1], cos_q[1], sin_q[2],
                        cos_q[2], ta_q, tb_q));
    tc_sh    = {{2{tc_q[31]}}, tc_q, 14'd0};
    case (op.ini)
      INI_PLUS:  mul_init = tc_sh;
      INI_MINUS: mul_init = -tc_sh;
      default:   mul_init = '0;
    endcase
    rnd = rnd_sat(prod, op.ini != INI_NONE);
  end

  emr_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_CSTART),
    .phase_i (ang_q[ax_q]),
    .done_o  (cor_done),
    .res_o   (cor_res)
  );

  emr_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_MSTART),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .init_i  (mul_init),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // Sequencer, phase accumulators and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ph_x_q      <= '0;
      ph_y_q      <= '0;
      ph_z_q      <= '0;
      ax_q        <= '0;
      op_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && mat_out.ready && (state_q != S_OUT)) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (step_in.valid) begin
            ph_x_q  <= ph_x_q + step_in.step_x;
            ph_y_q  <= ph_y_q + step_in.step_y;
            ph_z_q  <= ph_z_q + step_in.step_z;
            ax_q    <= '0;
            state_q <= S_CSTART;
          end
        end
        S_CSTART: state_q <= S_CWAIT;
        S_CWAIT: begin
          if (cor_done) begin
            if (ax_q == 2'd2) begin
              op_q    <= '0;
              state_q <= S_MSTART;
            end else begin
              ax_q    <= ax_q + 2'd1;
              state_q <= S_CSTART;
            end
          end
        end
        S_MSTART: state_q <= S_MWAIT;
        S_MWAIT: begin
          if (mul_done) begin
            if (op_q == 4'(NumOps - 1)) begin
              state_q <= S_OUT;
            end else begin
              op_q    <= op_q + 4'd1;
              state_q <= S_MSTART;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_q || mat_out.ready) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Working data: angles, sines, cosines, partial products, matrix entries
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && step_in.valid) begin
      ang_q[0] <= ph_x_q;
      ang_q[1] <= ph_y_q;
      ang_q[2] <= ph_z_q;
    end
    if (state_q == S_CWAIT && cor_done) begin
      sin_q[ax_q] <= cor_res.sin;
      cos_q[ax_q] <= cor_res.cos;
    end
    if (state_q == S_MWAIT && mul_done) begin
      case (op.dst)
        DST_M00: m00_q <= rnd;
        DST_M01: m01_q <= rnd;
        DST_M02: m02_q <= rnd;
        DST_M10: m10_q <= rnd;
        DST_M11: m11_q <= rnd;
        DST_M12: m12_q <= rnd;
        DST_M21: m21_q <= rnd;
        DST_M22: m22_q <= rnd;
        DST_TA:  ta_q  <= prod[31:0];
        DST_TB:  tb_q  <= prod[31:0];
        default: tc_q  <= prod[31:0];
      endcase
    end
    if (state_q == S_OUT && (!out_valid_q || mat_out.ready)) begin
      mat_out.m00 <= m00_q;
      mat_out.m01 <= m01_q;
      mat_out.m02 <= m02_q;
      mat_out.m10 <= m10_q;
      mat_out.m11 <= m11_q;
      mat_out.m12 <= m12_q;
      mat_out.m20 <= -sin_q[1];
      mat_out.m21 <= m21_q;
      mat_out.m22 <= m22_q;
    end
  end

  assign step_in.ready = (state_q == S_IDLE);
  assign mat_out.valid = out_valid_q;

endmodule
`default_nettype wire

/* tb/emr_tb_pkg.sv */
// Testbench package: matrix prediction for the Euler matrix generator.
`timescale 1ns / 1ps
package emr_tb_pkg;

  typedef struct packed {
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } mat_t;

  typedef struct packed {
    logic signed [15:0] sx, sy, sz;
  } step_t;

  localparam int unsigned NumArcs = 14;
  localparam longint Unit = 16384;

  // Round half up by sh bits, clamp to +-1.0
  function automatic longint round_clamp(input longint v, input int sh);
    longint r;
    r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
    if (r > Unit) r = Unit;
    if (r < -Unit) r = -Unit;
    return r;
  endfunction

  // Folded CORDIC sine/cosine of a 16-bit phase
  function automatic void phase_trig(input logic [15:0] ph, output longint s,
                                     output longint c);
    int arcs [NumArcs] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10,
                           5, 3, 1};
    int ang;
    bit flip;
    longint x, y, dx, dy;
    ang = int'($signed(ph));
    flip = 0;
    x = 39797;
    y = 0;
    if (ang > 16384) begin
      ang -= 32768;
      flip = 1;
    end else if (ang < -16384) begin
      ang += 32768;
      flip = 1;
    end
    for (int i = 0; i < NumArcs; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (ang >= 0) begin
        x -= dx; y += dy; ang -= arcs[i];
      end else begin
        x += dx; y -= dy; ang += arcs[i];
      end
    end
    c = round_clamp(x, 2);
    s = round_clamp(y, 2);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endfunction

  // Matrix Rz*Ry*Rx from the current phases
  function automatic mat_t euler_matrix(input logic [15:0] px, input logic [15:0] py,
                                        input logic [15:0] pz);
    longint sx, cx, sy, cy, sz, cz;
    mat_t m;
    phase_trig(px, sx, cx);
    phase_trig(py, sy, cy);
    phase_trig(pz, sz, cz);
    m.m00 = 16'(round_clamp(cz * cy, 14));
    m.m01 = 16'(round_clamp(cz * sy * sx - sz * cx * Unit, 28));
    m.m02 = 16'(round_clamp(cz * sy * cx + sz * sx * Unit, 28));
    m.m10 = 16'(round_clamp(sz * cy, 14));
    m.m11 = 16'(round_clamp(sz * sy * sx + cz * cx * Unit, 28));
    m.m12 = 16'(round_clamp(sz * sy * cx - cz * sx * Unit, 28));
    m.m20 = 16'(-sy);
    m.m21 = 16'(round_clamp(cy * sx, 14));
    m.m22 = 16'(round_clamp(cy * cx, 14));
    return m;
  endfunction

endpackage

/* tb/euler_rotation_matrix_gen_tb.sv */
// Testbench top: drives angle steps, checks each matrix against the predictor.
`timescale 1ns / 1ps
module euler_rotation_matrix_gen_tb;
  import emr_tb_pkg::*;

  localparam int NumRandom = 1630;
  localparam int NumDirected = 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  emr_step_if step_ch ();
  emr_mat_if  mat_ch ();

  euler_rotation_matrix_gen dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_in (step_ch.sink),
    .mat_out (mat_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted phases and pending matrices
  logic [15:0] phx, phy, phz;
  mat_t        mat_q[$];
  int          errors = 0;
  bit          stim_done = 0;

  // Directed steps; the known flag is clear on every row, so each matrix comes from the predictor
  typedef struct {
    step_t st;
    bit    known;
    mat_t  m;
  } row_t;
  row_t dir_tab [NumDirected];

  initial begin
    dir_tab[0] = '{'{16384, 0, 0}, 0, '0};          // after reset: all phases zero
    dir_tab[1] = '{'{-16384, 16384, 0}, 0, '0};
    dir_tab[2] = '{'{0, -16384, 16384}, 0, '0};
    dir_tab[3] = '{'{16384, 16384, -16384}, 0, '0};
    dir_tab[4] = '{'{32767, 32767, 32767}, 0, '0};
    dir_tab[5] = '{'{-32768, -32768, -32768}, 0, '0};
    dir_tab[6] = '{'{1, 1, 1}, 0, '0};
    dir_tab[7] = '{'{-1, -1, -1}, 0, '0};
    dir_tab[8] = '{'{16383, 16385, 8192}, 0, '0};
    dir_tab[9] = '{'{-16385, -16383, -8192}, 0, '0};
    dir_tab[10] = '{'{-1, 0, 0}, 0, '0};
    dir_tab[11] = '{'{-1, 0, 0}, 0, '0};
    dir_tab[12] = '{'{16'h5555, 16'h2aaa, 16'h7fff}, 0, '0};
    dir_tab[13] = '{'{16'haaaa, 16'hd555, 16'h8000}, 0, '0};
    dir_tab[14] = '{'{32767, -32768, 12345}, 0, '0};
    dir_tab[15] = '{'{-12345, 4096, -4096}, 0, '0};
    dir_tab[16] = '{'{0, 0, 0}, 0, '0};
    dir_tab[17] = '{'{0, 0, 0}, 0, '0};
    dir_tab[18] = '{'{100, -100, 200}, 0, '0};
    dir_tab[19] = '{'{-7, 9, -11}, 0, '0};
  end

  task automatic send_step(input step_t st, input bit known, input mat_t m);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      step_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    step_ch.valid  <= 1'b1;
    step_ch.step_x <= st.sx;
    step_ch.step_y <= st.sy;
    step_ch.step_z <= st.sz;
    do @(posedge clk_i); while (!step_ch.ready);
    mat_q.push_back(known ? m : euler_matrix(phx, phy, phz));
    phx = phx + st.sx;
    phy = phy + st.sy;
    phz = phz + st.sz;
  endtask

  // Stimulus
  initial begin
    step_t st;
    step_ch.valid  <= 1'b0;
    step_ch.step_x <= '0;
    step_ch.step_y <= '0;
    step_ch.step_z <= '0;
    phx = '0; phy = '0; phz = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tab[i]) send_step(dir_tab[i].st, dir_tab[i].known, dir_tab[i].m);
    step_ch.valid <= 1'b0;
    // let the pipe drain once before random traffic
    while (mat_q.size() != 0) @(posedge clk_i);
    for (int n = 0; n < NumRandom; n++) begin
      case ($urandom_range(0, 3))
        0: st = '{16'($urandom), 16'($urandom), 16'($urandom)};
        1: st = '{16'($signed($urandom_range(0, 64)) - 32),
                  16'($signed($urandom_range(0, 64)) - 32),
                  16'($signed($urandom_range(0, 64)) - 32)};
        2: st = '{16'($urandom_range(0, 3) * 16384), 16'($urandom_range(0, 3) * 16384),
                  16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1)};
        default: st = '{16'($urandom_range(0, 4096)), 16'($urandom),
                        16'($urandom_range(0, 2048))};
      endcase
      send_step(st, 0, '0);
    end
    step_ch.valid <= 1'b0;
    stim_done = 1;
  end

  // Result side: random stalls and checking
  initial begin
    mat_t exp_m, got;
    int stall;
    mat_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        mat_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      mat_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!mat_ch.valid);
      got = '{mat_ch.m00, mat_ch.m01, mat_ch.m02, mat_ch.m10, mat_ch.m11, mat_ch.m12,
              mat_ch.m20, mat_ch.m21, mat_ch.m22};
      if (mat_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected matrix %h", $time, got);
      end else begin
        exp_m = mat_q.pop_front();
        for (int k = 8; k >= 0; k--) begin
          if (exp_m[k*16 +: 16] !== got[k*16 +: 16]) begin
            errors++;
            $display("%0t: entry %0d expected %0d actual %0d", $time, 8 - k,
                     $signed(exp_m[k*16 +: 16]), $signed(got[k*16 +: 16]));
          end
        end
      end
    end
  end

  // End of run
  initial begin
    wait (stim_done);
    while (mat_q.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
    if (errors == 0 && mat_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
